### src/datediff_pkg.sv
// ----------------------------------------------------------------------------
// Date difference package
// Field widths, sequencer states, datapath commands and calendar tables.
// ----------------------------------------------------------------------------
package datediff_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned DAYS_W   = 22;
  localparam int unsigned ORDER_W  = 2;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned SERIAL_W = 23;
  localparam int unsigned Q25_W    = 10;
  localparam int unsigned CENT_W   = 8;
  localparam int unsigned LDAYS_W  = 12;

  // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT for x below 43690
  localparam int unsigned DIV25_MUL   = 10486;
  localparam int unsigned DIV25_SHIFT = 18;

  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_LEAP,
    ST_A_CENT,
    ST_A_MUL,
    ST_A_SUM,
    ST_B_LEAP,
    ST_B_CENT,
    ST_B_MUL,
    ST_B_SUM,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LEAP,
    OP_CENT,
    OP_MUL,
    OP_SUM,
    OP_STORE
  } op_e;

  typedef struct packed {
    logic load;
    logic sel_b;
    op_e  op;
  } cmd_t;

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### src/datediff_in_if.sv
// ----------------------------------------------------------------------------
// Date pair channel
// Valid/ready channel carrying two calendar dates per item.
// ----------------------------------------------------------------------------
interface datediff_in_if import datediff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_a;
  logic [MONTH_W-1:0] month_a;
  logic [YEAR_W-1:0]  year_a;
  logic [DAY_W-1:0]   day_b;
  logic [MONTH_W-1:0] month_b;
  logic [YEAR_W-1:0]  year_b;

  modport source (output valid, day_a, month_a, year_a, day_b, month_b, year_b,
                  input ready);
  modport sink (input valid, day_a, month_a, year_a, day_b, month_b, year_b,
                output ready);
endinterface

### src/datediff_out_if.sv
// ----------------------------------------------------------------------------
// Date difference result channel
// Valid/ready channel carrying one difference result per item.
// ----------------------------------------------------------------------------
interface datediff_out_if import datediff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAYS_W-1:0]  days_apart;
  logic [ORDER_W-1:0] order;
  logic [DOY_W-1:0]   day_of_year_a;
  logic               leap_a;
  logic               invalid;

  modport source (output valid, days_apart, order, day_of_year_a, leap_a, invalid,
                  input ready);
  modport sink (input valid, days_apart, order, day_of_year_a, leap_a, invalid,
                output ready);
endinterface

### src/datediff_ctrl.sv
// ----------------------------------------------------------------------------
// Date difference controller
// Sequences the datapath through both dates and owns the handshakes.
// ----------------------------------------------------------------------------
module datediff_ctrl import datediff_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   store;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.sel_b  = 1'b0;
    cmd_o.op     = OP_NONE;
    in_ready_o   = 1'b0;
    store        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_A_LEAP;
        end
      end
      ST_A_LEAP: begin
        cmd_o.op = OP_LEAP;
        state_d  = ST_A_CENT;
      end
      ST_A_CENT: begin
        cmd_o.op = OP_CENT;
        state_d  = ST_A_MUL;
      end
      ST_A_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_A_SUM;
      end
      ST_A_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_B_LEAP;
      end
      ST_B_LEAP: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.op    = OP_LEAP;
        state_d     = ST_B_CENT;
      end
      ST_B_CENT: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.op    = OP_CENT;
        state_d     = ST_B_MUL;
      end
      ST_B_MUL: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.op    = OP_MUL;
        state_d     = ST_B_SUM;
      end
      ST_B_SUM: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.op    = OP_SUM;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_STORE;
          store    = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (store) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/datediff_dp.sv
// ----------------------------------------------------------------------------
// Date difference datapath
// Converts each date to a day serial with divide-by-25 multipliers shared by both
// dates, then subtracts the serials and registers the result.
// ----------------------------------------------------------------------------
module datediff_dp import datediff_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  input  logic [DAY_W-1:0]   day_a_i,
  input  logic [MONTH_W-1:0] month_a_i,
  input  logic [YEAR_W-1:0]  year_a_i,
  input  logic [DAY_W-1:0]   day_b_i,
  input  logic [MONTH_W-1:0] month_b_i,
  input  logic [YEAR_W-1:0]  year_b_i,
  output logic [DAYS_W-1:0]  days_apart_o,
  output logic [ORDER_W-1:0] order_o,
  output logic [DOY_W-1:0]   day_of_year_a_o,
  output logic               leap_a_o,
  output logic               invalid_o
);

  localparam int unsigned YCMP_W = 17;
  localparam int unsigned KEY_W  = YEAR_W + MONTH_W + DAY_W;

  logic [DAY_W-1:0]    da_q, db_q;
  logic [MONTH_W-1:0]  ma_q, mb_q;
  logic [YEAR_W-1:0]   ya_q, yb_q;
  logic [Q25_W-1:0]    q25_q;
  logic [CENT_W-1:0]   cent_q;
  logic                leap_cur_q, leap_a_q, bad_q;
  logic [SERIAL_W-1:0] p365_q, serial_a_q, serial_b_q;
  logic [LDAYS_W-1:0]  ldays_q;
  logic [DOY_W-1:0]    ord_q, doy_a_q;

  logic [DAYS_W-1:0]   days_apart_q;
  logic [ORDER_W-1:0]  order_q;
  logic [DOY_W-1:0]    doy_out_q;
  logic                leap_out_q, invalid_out_q;

  logic [DAY_W-1:0]    d_cur;
  logic [MONTH_W-1:0]  m_cur;
  logic [YEAR_W-1:0]   y_cur, p_cur, y25;
  logic [11:0]         pq;
  logic [27:0]         prod_y;
  logic [25:0]         prod_c;
  logic                leap_cur, date_ok;
  logic [DAY_W-1:0]    lim;
  logic [DOY_W-1:0]    ord_cur;
  logic [SERIAL_W-1:0] apart;
  logic [KEY_W-1:0]    key_a, key_b;
  logic [ORDER_W-1:0]  order_cur;

  always_comb begin
    d_cur  = cmd_i.sel_b ? db_q : da_q;
    m_cur  = cmd_i.sel_b ? mb_q : ma_q;
    y_cur  = cmd_i.sel_b ? yb_q : ya_q;
    p_cur  = y_cur - 14'd1;
    pq     = p_cur[13:2];
    prod_y = 28'(y_cur) * 28'(DIV25_MUL);
    prod_c = 26'(pq) * 26'(DIV25_MUL);
    y25    = 14'({4'b0, q25_q} * 14'd25);
    // divisible by 4, and either not by 25 or by 16
    leap_cur = (y_cur[1:0] == 2'b00) && ((y_cur != y25) || (y_cur[3:0] == 4'b0000));
    lim      = month_len(m_cur, leap_cur_q);
    date_ok  = (m_cur >= 4'd1) && (m_cur <= 4'd12) && (y_cur != '0) &&
               (YCMP_W'(y_cur) <= YCMP_W'(MAX_YEAR)) &&
               (d_cur != '0) && (d_cur <= lim);
    ord_cur  = days_before(m_cur) + DOY_W'(d_cur) +
               DOY_W'((m_cur > 4'd2) && leap_cur_q);
    apart    = (serial_a_q > serial_b_q) ? serial_a_q - serial_b_q
                                         : serial_b_q - serial_a_q;
    key_a    = {ya_q, ma_q, da_q};
    key_b    = {yb_q, mb_q, db_q};
    if (key_a == key_b) begin
      order_cur = ORDER_EQUAL;
    end else if (key_a > key_b) begin
      order_cur = ORDER_LATER;
    end else begin
      order_cur = ORDER_EARLIER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      da_q  <= day_a_i;
      ma_q  <= month_a_i;
      ya_q  <= year_a_i;
      db_q  <= day_b_i;
      mb_q  <= month_b_i;
      yb_q  <= year_b_i;
      bad_q <= 1'b0;
    end
    case (cmd_i.op)
      OP_LEAP: q25_q <= prod_y[DIV25_SHIFT +: Q25_W];
      OP_CENT: begin
        leap_cur_q <= leap_cur;
        cent_q     <= prod_c[DIV25_SHIFT +: CENT_W];
        if (!cmd_i.sel_b) begin
          leap_a_q <= leap_cur;
        end
      end
      OP_MUL: begin
        p365_q  <= SERIAL_W'(p_cur) * SERIAL_W'(365);
        ldays_q <= pq - LDAYS_W'(cent_q) + LDAYS_W'(cent_q >> 2);
        ord_q   <= ord_cur;
        bad_q   <= bad_q | !date_ok;
      end
      OP_SUM: begin
        if (cmd_i.sel_b) begin
          serial_b_q <= p365_q + SERIAL_W'(ldays_q) + SERIAL_W'(ord_q) - SERIAL_W'(1);
        end else begin
          serial_a_q <= p365_q + SERIAL_W'(ldays_q) + SERIAL_W'(ord_q) - SERIAL_W'(1);
          doy_a_q    <= ord_q;
        end
      end
      OP_STORE: begin
        days_apart_q  <= bad_q ? '0 : apart[DAYS_W-1:0];
        order_q       <= order_cur;
        doy_out_q     <= bad_q ? '0 : doy_a_q;
        leap_out_q    <= leap_a_q;
        invalid_out_q <= bad_q;
      end
      default: ;
    endcase
  end

  assign days_apart_o    = days_apart_q;
  assign order_o         = order_q;
  assign day_of_year_a_o = doy_out_q;
  assign leap_a_o        = leap_out_q;
  assign invalid_o       = invalid_out_q;

endmodule

### src/date_difference_days.sv
// ----------------------------------------------------------------------------
// Date difference, top level
// Days between two Gregorian dates, their order, and calendar facts of the
// first date.
//
//   channel | direction | carries
//   in_i    | sink      | day_a, month_a, year_a, day_b, month_b, year_b
//   out_o   | source    | days_apart, order, day_of_year_a, leap_a, invalid
//
// An item runs from acceptance to result in four steps per date
// (divide-by-25, century count, year multiply, serial sum) on multipliers
// shared by both dates, plus a store step.
// The input is ready again the cycle after the store, so items do not overlap.
// A waiting result stalls only the store step of the next item.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module date_difference_days import datediff_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  datediff_in_if.sink   in_i,
  datediff_out_if.source out_o
);

  cmd_t cmd;

  datediff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  datediff_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .day_a_i         (in_i.day_a),
    .month_a_i       (in_i.month_a),
    .year_a_i        (in_i.year_a),
    .day_b_i         (in_i.day_b),
    .month_b_i       (in_i.month_b),
    .year_b_i        (in_i.year_b),
    .days_apart_o    (out_o.days_apart),
    .order_o         (out_o.order),
    .day_of_year_a_o (out_o.day_of_year_a),
    .leap_a_o        (out_o.leap_a),
    .invalid_o       (out_o.invalid)
  );

endmodule

### src/datediff_checker.sv
// ----------------------------------------------------------------------------
// Date difference checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module datediff_checker import datediff_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [DAYS_W-1:0]  days_apart_i,
  input logic [ORDER_W-1:0] order_i,
  input logic [DOY_W-1:0]   day_of_year_a_i,
  input logic               invalid_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(days_apart_i) && $stable(order_i))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && invalid_i |-> days_apart_i == '0 && day_of_year_a_i == '0)
    else $error("invalid result with nonzero counts");

  a_equal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !invalid_i && order_i == ORDER_EQUAL |-> days_apart_i == '0)
    else $error("equal dates with nonzero distance");

  a_apart_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !invalid_i && order_i != ORDER_EQUAL |->
      days_apart_i != '0 && day_of_year_a_i != '0)
    else $error("distinct valid dates with zero distance or ordinal");

  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> order_i == ORDER_EQUAL || order_i == ORDER_LATER ||
                    order_i == ORDER_EARLIER)
    else $error("order code out of range");

endmodule

bind date_difference_days datediff_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .days_apart_i    (out_o.days_apart),
  .order_i         (out_o.order),
  .day_of_year_a_i (out_o.day_of_year_a),
  .invalid_i       (out_o.invalid)
);
